// ===== design/plal_pkg.sv =====
// Shared types and constants for the port link/activity LED block.
`default_nettype none

package plal_pkg;

  // Number of LED ports that carry state
  localparam int PORT_COUNT = 8;
  // Port-state memory address width
  localparam int ADDR_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  // Width used to compare a port index against PORT_COUNT (holds 64)
  localparam int PORT_CMP_W = 7;

  // Status byte codes and masks
  localparam logic [7:0] LED_ON_BIT   = 8'h02;
  localparam logic [7:0] LED_TOGGLE   = 8'h01;
  localparam logic [7:0] LED_LOW_MASK = 8'h03;
  localparam logic [7:0] LED_KEEP     = 8'hFC;
  localparam logic [7:0] LED_OFF      = 8'h00;

  // One port's stored state
  typedef struct packed {
    logic [7:0]  status;
    logic [31:0] last_rx;
    logic [31:0] last_tx;
  } plal_entry_t;

  localparam int ENTRY_W = $bits(plal_entry_t);

endpackage

`default_nettype wire

// ===== design/plal_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none

module plal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, read port returns old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/port_link_activity_led_top.sv =====
// Top level of the port link/activity LED status generator.
`default_nettype none

// Takes one port observation per transaction and returns that port's new LED
// status byte with a write strobe. Sustained rate is one observation per clock
// cycle unless the output stalls. The port-state memory read and the stage 1
// capture share the accepting edge, and the output register loads as stage 1
// advances. Per-port state (status byte, last receive and transmit counts)
// lives in one memory with one read and one write port; an observation of the
// same port right after another is served by forwarding the last write.
// Entries not written since reset read as zero through a valid bit per port,
// so no clearing pass is needed. The flash phase shared by all ports of a
// scan restarts on first_of_scan.
module port_link_activity_led_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // port[2:0], first_of_scan[3], base_x_mode[4], link_up[5], rx_count[37:6],
  // tx_count[69:38], rx_clear_on_read[70], tx_clear_on_read[71]
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_port[2:0], led_code[10:3], write_strobe[11], zero pad[15:12]
  output logic      [15:0] m_tdata
);

  import plal_pkg::*;

  // Input field unpacking
  logic [2:0]        in_port;
  logic [ADDR_W-1:0] in_addr;
  assign in_port = s_tdata[2:0];
  assign in_addr = ADDR_W'(in_port);

  // Stage 1: item waiting on the memory read
  logic              s1_valid;
  logic [2:0]        s1_port;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_in_range;
  logic              s1_first;
  logic              s1_basex;
  logic              s1_link;
  logic [31:0]       s1_rx;
  logic [31:0]       s1_tx;
  logic              s1_rx_clr;
  logic              s1_tx_clr;
  logic              s1_entry_valid;
  logic              s1_advance;

  // Port state bookkeeping
  logic [PORT_COUNT-1:0] entry_valid;
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  plal_entry_t           fwd_data;
  logic                  flash_taken;
  logic [7:0]            flash_value;

  logic                  accept;
  logic                  mem_we;
  logic [ENTRY_W-1:0]    mem_rdata;
  plal_entry_t           entry;
  plal_entry_t           entry_next;

  // Combinational results
  logic       any_clr;
  logic       rx_diff;
  logic       tx_diff;
  logic       active;
  logic       taken_eff;
  logic [7:0] code;
  logic       wr;
  logic [7:0] out_code;
  logic       out_wr;

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  plal_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PORT_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(s1_addr),
    .wdata(entry_next),
    .re   (accept),
    .raddr(in_addr),
    .rdata(mem_rdata)
  );

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_port        <= in_port;
      s1_addr        <= in_addr;
      s1_in_range    <= PORT_CMP_W'(in_port) < PORT_CMP_W'(PORT_COUNT);
      s1_first       <= s_tdata[3];
      s1_basex       <= s_tdata[4];
      s1_link        <= s_tdata[5];
      s1_rx          <= s_tdata[37:6];
      s1_tx          <= s_tdata[69:38];
      s1_rx_clr      <= s_tdata[70];
      s1_tx_clr      <= s_tdata[71];
      s1_entry_valid <= entry_valid[in_addr];
    end
  end

  // Entry selection: latest write, then memory, then reset value
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      entry = fwd_data;
    end else if (s1_entry_valid) begin
      entry = plal_entry_t'(mem_rdata);
    end else begin
      entry = '0;
    end
  end

  // Activity detection and status update
  always_comb begin
    any_clr   = s1_rx_clr || s1_tx_clr;
    rx_diff   = s1_rx != entry.last_rx;
    tx_diff   = s1_tx != entry.last_tx;
    active    = (s1_rx_clr && (s1_rx != 32'd0)) || (s1_tx_clr && (s1_tx != 32'd0)) ||
                (!any_clr && (rx_diff || tx_diff));
    taken_eff = s1_first ? 1'b0 : flash_taken;
    code      = entry.status;
    wr        = 1'b0;
    entry_next = entry;
    if (s1_link) begin
      if (active) begin
        code = taken_eff ? flash_value : ((entry.status | LED_ON_BIT) ^ LED_TOGGLE);
        wr   = 1'b1;
      end else if ((entry.status & LED_LOW_MASK) != LED_ON_BIT) begin
        code = (entry.status & LED_KEEP) | LED_ON_BIT;
        wr   = 1'b1;
      end
      if (!any_clr && rx_diff) begin
        entry_next.last_rx = s1_rx;
      end else if (!any_clr && tx_diff) begin
        entry_next.last_tx = s1_tx;
      end
    end else if ((entry.status & LED_LOW_MASK) != LED_OFF) begin
      code = entry.status & LED_KEEP;
      wr   = 1'b1;
    end
    entry_next.status = code;
    out_code = entry.status;
    out_wr   = 1'b0;
    if (!s1_in_range) begin
      out_code = LED_OFF;
    end else if (s1_basex) begin
      out_code = code;
      out_wr   = wr;
    end
  end

  assign mem_we = s1_advance && s1_in_range && s1_basex;

  // State write-back, forwarding copy and flash phase
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd_valid   <= 1'b0;
      flash_taken <= 1'b0;
      flash_value <= 8'h00;
    end else if (s1_advance) begin
      if (mem_we) begin
        entry_valid[s1_addr] <= 1'b1;
        fwd_valid            <= 1'b1;
      end
      if (mem_we && s1_link && active && !taken_eff) begin
        flash_taken <= 1'b1;
        flash_value <= code;
      end else begin
        flash_taken <= taken_eff;
      end
    end
    if (mem_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= entry_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_advance) begin
      m_tdata <= {4'b0000, out_wr, out_code, s1_port};
    end
  end

  // A written status byte never carries the low-bit pattern 01
  a_strobe_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11]) |-> (m_tdata[4:3] != 2'b01))
    else $error("written LED code has invalid low bits");

  // An item blocked by the output register stays in stage 1
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_port)))
    else $error("stage 1 item lost while output stalled");

  // A flash taken by an active port is recorded for the rest of the scan
  a_flash_taken: assert property (@(posedge clk) disable iff (rst)
    (mem_we && s1_link && active) |=> flash_taken)
    else $error("flash phase not recorded");

  // Ports beyond the configured count never strobe
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (PORT_CMP_W'(m_tdata[2:0]) >= PORT_CMP_W'(PORT_COUNT)))
      |-> (!m_tdata[11] && (m_tdata[10:3] == LED_OFF)))
    else $error("out-of-range port produced a status");

endmodule

`default_nettype wire
